FILE: hw/rtl/stpid_pkg.sv
// Shared widths, register codes, control word layout and microcode for the steering PID.
`timescale 1ns / 1ps

package stpid_pkg;

  localparam int ANGLE_W   = 16;
  localparam int FRAC_BITS = 4;
  localparam int INTEG_W   = 16;
  localparam int TORQUE_W  = 16;
  localparam int GAIN_W    = 10;
  localparam int LIM_W     = 15;
  localparam int CFG_W     = 15;
  localparam int IDX_W     = 3;

  localparam int ERR_W  = ANGLE_W + 1;
  localparam int SUM_W  = ((ERR_W > INTEG_W) ? ERR_W : INTEG_W) + 1;
  localparam int MA_W   = ERR_W + GAIN_W + 1;
  localparam int MB_W   = GAIN_W + 1;
  localparam int P_W    = MA_W + MB_W;
  localparam int ACC_W  = P_W + 1;
  localparam int STEP_W = 3;

  localparam logic [GAIN_W-1:0] RST_GAIN_PROP  = GAIN_W'(60);
  localparam logic [GAIN_W-1:0] RST_GAIN_INTEG = GAIN_W'(13);
  localparam logic [GAIN_W-1:0] RST_GAIN_DERIV = GAIN_W'(10);
  localparam logic [GAIN_W-1:0] RST_INV_PERIOD = GAIN_W'(100);
  localparam logic [LIM_W-1:0]  RST_INTEG_LIM  = LIM_W'(1600);
  localparam logic [LIM_W-1:0]  RST_TORQUE_LIM = LIM_W'(2000);
  localparam logic [LIM_W-1:0]  RST_SMALL_ERR  = LIM_W'(160);

  typedef enum logic [IDX_W-1:0] {
    REG_GAIN_PROP   = 3'd0,
    REG_GAIN_INTEG  = 3'd1,
    REG_GAIN_DERIV  = 3'd2,
    REG_INV_PERIOD  = 3'd3,
    REG_INTEG_LIMIT = 3'd4,
    REG_TORQUE_LIM  = 3'd5,
    REG_SMALL_ERR   = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    A_ERR = 2'd0,
    A_INT = 2'd1,
    A_DLT = 2'd2,
    A_PRD = 2'd3
  } a_sel_t;

  typedef enum logic [1:0] {
    B_GP = 2'd0,
    B_GI = 2'd1,
    B_IP = 2'd2,
    B_KD = 2'd3
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_NOP = 2'd0,
    ACC_LD  = 2'd1,
    ACC_ADD = 2'd2,
    ACC_SUB = 2'd3
  } acc_op_t;

  typedef enum logic [1:0] {
    INT_NOP = 2'd0,
    INT_ACC = 2'd1,
    INT_CLR = 2'd2
  } int_op_t;

  typedef struct packed {
    logic    mul_en;
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    acc_op_t acc_op;
    logic    diff_en;
    logic    kd_ld;
    int_op_t integ_op;
    logic    out_ld;
    logic    jmp_man;
    logic    last;
  } ctrl_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_prop;
    logic [GAIN_W-1:0] gain_integ;
    logic [GAIN_W-1:0] gain_deriv;
    logic [GAIN_W-1:0] inv_period;
    logic [LIM_W-1:0]  integ_limit;
    logic [LIM_W-1:0]  torque_limit;
    logic [LIM_W-1:0]  small_err;
  } cfg_t;

  localparam logic [STEP_W-1:0] STEP_MANUAL = STEP_W'(7);

  // Control program. Each multiply lands in the product register, where the
  // accumulator or the next multiply picks it up in the following step.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t cw;
    cw = '0;
    case (step)
      3'd0: begin
        cw.diff_en = 1'b1;
        cw.jmp_man = 1'b1;
      end
      3'd1: begin
        cw.mul_en   = 1'b1;
        cw.a_sel    = A_ERR;
        cw.b_sel    = B_GP;
        cw.integ_op = INT_ACC;
        cw.kd_ld    = 1'b1;
      end
      3'd2: begin
        cw.mul_en = 1'b1;
        cw.a_sel  = A_INT;
        cw.b_sel  = B_GI;
        cw.acc_op = ACC_LD;
      end
      3'd3: begin
        cw.mul_en = 1'b1;
        cw.a_sel  = A_DLT;
        cw.b_sel  = B_IP;
        cw.acc_op = ACC_ADD;
      end
      3'd4: begin
        cw.mul_en = 1'b1;
        cw.a_sel  = A_PRD;
        cw.b_sel  = B_KD;
      end
      3'd5: begin
        cw.acc_op = ACC_SUB;
      end
      3'd6: begin
        cw.out_ld = 1'b1;
        cw.last   = 1'b1;
      end
      3'd7: begin
        cw.integ_op = INT_CLR;
        cw.last     = 1'b1;
      end
      default: begin
        cw.last = 1'b1;
      end
    endcase
    return cw;
  endfunction

endpackage

FILE: hw/rtl/stpid_seq.sv
// Step counter and microcode sequencer for the steering PID.
`timescale 1ns / 1ps

module stpid_seq
  import stpid_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  logic  manual,
  input  logic  out_stall,
  output logic  idle,
  output ctrl_t ctrl
);

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  ctrl_t             cw;
  logic              go;

  assign cw   = ucode(step_r);
  // The output step waits while the previous result is still held.
  assign go   = busy_r && !(cw.out_ld && out_stall);
  assign ctrl = go ? cw : '0;
  assign idle = !busy_r;

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        step_nxt = '0;
      end
    end else if (go) begin
      if (cw.last) begin
        busy_nxt = 1'b0;
      end else if (cw.jmp_man && manual) begin
        step_nxt = STEP_MANUAL;
      end else begin
        step_nxt = step_r + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

endmodule

FILE: hw/rtl/stpid_dp.sv
// Datapath of the steering PID: shared multiplier, accumulator, integral and output register.
`timescale 1ns / 1ps

module stpid_dp
  import stpid_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic signed [ANGLE_W-1:0]  meas_in,
  input  logic signed [ANGLE_W-1:0]  targ_in,
  input  logic                       manual_in,
  input  cfg_t                       cfg,
  input  ctrl_t                      ctrl,
  input  logic                       out_ready,
  output logic                       manual,
  output logic                       out_stall,
  output logic                       out_valid,
  output logic signed [TORQUE_W-1:0] out_torque
);

  logic signed [ANGLE_W-1:0]  meas_r, targ_r, last_r;
  logic                       man_r, lvalid_r;
  logic signed [ERR_W-1:0]    err_r, dlt_r;
  logic signed [INTEG_W-1:0]  integ_r;
  logic [GAIN_W-1:0]          kd_r;
  logic signed [P_W-1:0]      prod_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic                       out_valid_r;
  logic signed [TORQUE_W-1:0] out_torque_r;

  logic signed [MA_W-1:0]   mul_a;
  logic [GAIN_W-1:0]        mul_bu;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [SUM_W-1:0]  isum, ilim;
  logic [ERR_W-1:0]         err_mag;
  logic signed [ACC_W-1:0]  shifted, tlim;
  logic signed [TORQUE_W-1:0] sat;

  assign manual     = man_r;
  assign out_valid  = out_valid_r;
  assign out_torque = out_torque_r;
  assign out_stall  = out_valid_r && !out_ready;

  always_comb begin
    case (ctrl.a_sel)
      A_ERR:   mul_a = MA_W'(err_r);
      A_INT:   mul_a = MA_W'(integ_r);
      A_DLT:   mul_a = MA_W'(dlt_r);
      A_PRD:   mul_a = $signed(prod_r[MA_W-1:0]);
      default: mul_a = '0;
    endcase
    case (ctrl.b_sel)
      B_GP:    mul_bu = cfg.gain_prop;
      B_GI:    mul_bu = cfg.gain_integ;
      B_IP:    mul_bu = cfg.inv_period;
      B_KD:    mul_bu = kd_r;
      default: mul_bu = '0;
    endcase
  end

  assign mul_b    = $signed({1'b0, mul_bu});
  assign prod_ext = ACC_W'(prod_r);

  // Integral update with symmetric clamp.
  assign isum = SUM_W'(integ_r) + SUM_W'(err_r);
  assign ilim = $signed(SUM_W'(cfg.integ_limit));

  assign err_mag = err_r[ERR_W-1] ? ERR_W'(-err_r) : ERR_W'(err_r);

  // Arithmetic shift gives the floor of the fixed-point sum.
  assign shifted = acc_r >>> FRAC_BITS;
  assign tlim    = $signed(ACC_W'(cfg.torque_limit));

  always_comb begin
    if (shifted > tlim) begin
      sat = TORQUE_W'(tlim);
    end else if (shifted < -tlim) begin
      sat = TORQUE_W'(-tlim);
    end else begin
      sat = TORQUE_W'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      meas_r <= meas_in;
      targ_r <= targ_in;
      man_r  <= manual_in;
    end
    if (ctrl.diff_en) begin
      err_r <= ERR_W'(targ_r) - ERR_W'(meas_r);
      dlt_r <= lvalid_r ? (ERR_W'(meas_r) - ERR_W'(last_r)) : '0;
    end
    if (ctrl.kd_ld) begin
      kd_r <= (err_mag < ERR_W'(cfg.small_err)) ? (cfg.gain_deriv >> 1) : cfg.gain_deriv;
    end
    if (ctrl.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    case (ctrl.acc_op)
      ACC_LD:  acc_r <= prod_ext;
      ACC_ADD: acc_r <= acc_r + prod_ext;
      ACC_SUB: acc_r <= acc_r - prod_ext;
      default: acc_r <= acc_r;
    endcase
    if (ctrl.out_ld) begin
      out_torque_r <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r     <= '0;
      last_r      <= '0;
      lvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (ctrl.integ_op)
        INT_ACC: begin
          if (isum > ilim) begin
            integ_r <= INTEG_W'(ilim);
          end else if (isum < -ilim) begin
            integ_r <= INTEG_W'(-ilim);
          end else begin
            integ_r <= INTEG_W'(isum);
          end
        end
        INT_CLR: integ_r <= '0;
        default: integ_r <= integ_r;
      endcase
      if (ctrl.out_ld) begin
        last_r      <= meas_r;
        lvalid_r    <= 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/steering_torque_pid_unit.sv
// Top level of the steering torque PID: configuration registers and unit wiring.
//
// Input channel (in_valid/in_ready) carries one request: measured angle,
// target angle and the manual flag. Output channel (out_valid/out_ready)
// returns one drive torque per non-manual request; manual requests clear the
// integral and return nothing.
// Timing: a request is taken when in_ready is high. A control program of up
// to seven steps then runs over one shared multiplier: a normal request
// shows its torque in the same cycle in which in_ready returns; a manual
// request runs only its difference step and the integral clear before
// in_ready returns. Either way a new request waits until the last one has
// left the sequencer. The steps of a normal request are the difference step,
// four multiplies on one multiplier, the final subtract and the output step.
// The result sits in an output register, so a new request is taken while a
// result still waits. If the receiver stalls, the next request runs up to
// its output step and holds there until the register is free.
// Reset (rst_n low at a clock edge) loads the default gains and limits,
// clears the integral, forgets the previous angle and drops out_valid.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
// and belong in idle periods only.
`timescale 1ns / 1ps

module steering_torque_pid_unit
  import stpid_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [ANGLE_W-1:0]  in_measured_angle,
  input  logic signed [ANGLE_W-1:0]  in_target_angle,
  input  logic                       in_manual_mode,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [TORQUE_W-1:0] out_drive_torque,
  input  logic                       cfg_we,
  input  logic [IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  cfg_t  cfg_r;
  ctrl_t ctrl;
  logic  idle, start, manual, out_stall;

  assign in_ready = idle;
  assign start    = in_valid && idle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_prop    <= RST_GAIN_PROP;
      cfg_r.gain_integ   <= RST_GAIN_INTEG;
      cfg_r.gain_deriv   <= RST_GAIN_DERIV;
      cfg_r.inv_period   <= RST_INV_PERIOD;
      cfg_r.integ_limit  <= RST_INTEG_LIM;
      cfg_r.torque_limit <= RST_TORQUE_LIM;
      cfg_r.small_err    <= RST_SMALL_ERR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_PROP:   cfg_r.gain_prop    <= cfg_data[GAIN_W-1:0];
        REG_GAIN_INTEG:  cfg_r.gain_integ   <= cfg_data[GAIN_W-1:0];
        REG_GAIN_DERIV:  cfg_r.gain_deriv   <= cfg_data[GAIN_W-1:0];
        REG_INV_PERIOD:  cfg_r.inv_period   <= cfg_data[GAIN_W-1:0];
        REG_INTEG_LIMIT: cfg_r.integ_limit  <= cfg_data[LIM_W-1:0];
        REG_TORQUE_LIM:  cfg_r.torque_limit <= cfg_data[LIM_W-1:0];
        REG_SMALL_ERR:   cfg_r.small_err    <= cfg_data[LIM_W-1:0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  stpid_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .manual    (manual),
    .out_stall (out_stall),
    .idle      (idle),
    .ctrl      (ctrl)
  );

  stpid_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (start),
    .meas_in    (in_measured_angle),
    .targ_in    (in_target_angle),
    .manual_in  (in_manual_mode),
    .cfg        (cfg_r),
    .ctrl       (ctrl),
    .out_ready  (out_ready),
    .manual     (manual),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_torque (out_drive_torque)
  );

endmodule

FILE: hw/rtl/stpid_chk.sv
// Port-level checker for the steering torque PID, bound to the top level.
`timescale 1ns / 1ps

module stpid_chk
  import stpid_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [TORQUE_W-1:0] out_drive_torque
);

  // Reset leaves the block ready and with no result pending.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  // An accepted request keeps in_ready low while the sequencer runs it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("request accepted while sequencer busy");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive_torque))
    else $error("stalled torque changed or dropped");

  // Saturation never yields the most negative code.
  a_torque_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_drive_torque != {1'b1, {(TORQUE_W-1){1'b0}}})
    else $error("torque outside symmetric range");

endmodule

bind steering_torque_pid_unit stpid_chk u_stpid_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_drive_torque (out_drive_torque)
);

FILE: tb/sv/tb_steering_torque_pid_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the steering torque PID unit: a directed table, then random phases.

module tb_steering_torque_pid_unit;
  import stpid_pkg::*;

  localparam int RAND_ITEMS    = 1450;
  localparam int PHASES        = 10;
  localparam int SETTLE_CYCLES = 12;
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [ANGLE_W-1:0]  meas;
    logic signed [ANGLE_W-1:0]  targ;
    logic                       manual;
    logic                       known;
    logic signed [TORQUE_W-1:0] torque;
  } steer_row_t;

  typedef struct {
    logic [CFG_W-1:0] gp, gi, gd, ip, il, tl, se;
  } raw_cfg_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [ANGLE_W-1:0]  in_measured_angle = '0;
  logic signed [ANGLE_W-1:0]  in_target_angle = '0;
  logic                       in_manual_mode = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [TORQUE_W-1:0] out_drive_torque;
  logic                       cfg_we = 1'b0;
  logic [IDX_W-1:0]           cfg_index = '0;
  logic [CFG_W-1:0]           cfg_data = '0;

  // Predictor state: configuration, accumulated error, previous angle.
  cfg_t    steer_cfg;
  longint  integ_sum;
  longint  prev_angle;
  bit      prev_seen;

  logic signed [TORQUE_W-1:0] torque_due[$];
  logic signed [TORQUE_W-1:0] due_torque;
  int                         fail_count = 0;

  int                         gap_pct = 30;
  int                         stall_pct = 30;
  bit                         calm = 1'b0;
  int                         stall_left = 0;
  logic signed [ANGLE_W-1:0]  prev_drive = '0;

  steer_row_t dir_rows[17];
  raw_cfg_t   raw;

  steering_torque_pid_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_measured_angle (in_measured_angle),
    .in_target_angle   (in_target_angle),
    .in_manual_mode    (in_manual_mode),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_drive_torque  (out_drive_torque),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  task automatic predict_pid(input logic signed [ANGLE_W-1:0] meas,
                             input logic signed [ANGLE_W-1:0] targ,
                             input logic manual, output bit produced,
                             output logic signed [TORQUE_W-1:0] torque);
    longint m, t, err, mag, vel, kd, sum;
    m = meas;
    t = targ;
    produced = 1'b0;
    torque = '0;
    if (manual) begin
      integ_sum = 0;
    end else begin
      vel = prev_seen ? (m - prev_angle) * longint'(steer_cfg.inv_period) : 0;
      err = t - m;
      integ_sum = clamp_sym(integ_sum + err, longint'(steer_cfg.integ_limit));
      mag = (err < 0) ? -err : err;
      kd = (mag < longint'(steer_cfg.small_err)) ? longint'(steer_cfg.gain_deriv >> 1)
                                                 : longint'(steer_cfg.gain_deriv);
      sum = err * longint'(steer_cfg.gain_prop) + integ_sum * longint'(steer_cfg.gain_integ)
            - vel * kd;
      // Arithmetic shift gives the floor, as the block must.
      torque = TORQUE_W'(clamp_sym(sum >>> FRAC_BITS, longint'(steer_cfg.torque_limit)));
      prev_angle = m;
      prev_seen = 1'b1;
      produced = 1'b1;
    end
  endtask

  task automatic apply_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    case (idx)
      REG_GAIN_PROP: begin
        steer_cfg.gain_prop = data[GAIN_W-1:0];
      end
      REG_GAIN_INTEG: begin
        steer_cfg.gain_integ = data[GAIN_W-1:0];
      end
      REG_GAIN_DERIV: begin
        steer_cfg.gain_deriv = data[GAIN_W-1:0];
      end
      REG_INV_PERIOD: begin
        steer_cfg.inv_period = data[GAIN_W-1:0];
      end
      REG_INTEG_LIMIT: begin
        steer_cfg.integ_limit = data[LIM_W-1:0];
      end
      REG_TORQUE_LIM: begin
        steer_cfg.torque_limit = data[LIM_W-1:0];
      end
      REG_SMALL_ERR: begin
        steer_cfg.small_err = data[LIM_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    apply_write(idx, data);
  endtask

  task automatic load_registers(input raw_cfg_t r, input bit poke_unused);
    write_reg(REG_GAIN_PROP, r.gp);
    write_reg(REG_GAIN_INTEG, r.gi);
    write_reg(REG_GAIN_DERIV, r.gd);
    write_reg(REG_INV_PERIOD, r.ip);
    write_reg(REG_INTEG_LIMIT, r.il);
    write_reg(REG_TORQUE_LIM, r.tl);
    write_reg(REG_SMALL_ERR, r.se);
    // The spare index must not disturb any register.
    if (poke_unused) write_reg(REG_UNUSED, CFG_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic sender_pause();
    int n;
    if (!calm && $urandom_range(99) < gap_pct) begin
      n = $urandom_range(12, 1);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_request(input logic signed [ANGLE_W-1:0] meas,
                              input logic signed [ANGLE_W-1:0] targ,
                              input logic manual, input bit known,
                              input logic signed [TORQUE_W-1:0] known_torque);
    bit                         produced;
    logic signed [TORQUE_W-1:0] torque;
    in_valid <= 1'b1;
    in_measured_angle <= meas;
    in_target_angle <= targ;
    in_manual_mode <= manual;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pid(meas, targ, manual, produced, torque);
    if (produced) torque_due.push_back(known ? known_torque : torque);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (torque_due.size() != 0) @(posedge clk);
    // A manual request may still be clearing the integral.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly slowly moving angles near the target, so the threshold and the
  // clamps are crossed often; the rest is full-range noise.
  task automatic next_random(output logic signed [ANGLE_W-1:0] meas,
                             output logic signed [ANGLE_W-1:0] targ,
                             output logic manual);
    int r;
    r = $urandom_range(99);
    manual = (r < 8);
    if (r < 25) begin
      meas = ANGLE_W'($urandom);
      targ = ANGLE_W'($urandom);
    end else begin
      meas = prev_drive + ANGLE_W'($urandom_range(64)) - ANGLE_W'(32);
      targ = meas + ANGLE_W'($urandom_range(800)) - ANGLE_W'(400);
    end
    prev_drive = meas;
  endtask

  function automatic logic [CFG_W-1:0] rand_gain();
    logic [CFG_W-1:0] v;
    v = CFG_W'($urandom_range(1023));
    if ($urandom_range(3) == 0) v[CFG_W-1:GAIN_W] = (CFG_W - GAIN_W)'($urandom);
    return v;
  endfunction

  function automatic logic [CFG_W-1:0] rand_limit();
    return ($urandom_range(1) != 0) ? CFG_W'($urandom_range(32767))
                                    : CFG_W'($urandom_range(4000));
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(99) < stall_pct) begin
      stall_left <= $urandom_range(12, 1) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (torque_due.size() == 0) begin
        $display("%0t: unexpected drive_torque, expected none, got %0d", $time,
                 out_drive_torque);
        fail_count++;
      end else begin
        due_torque = torque_due.pop_front();
        if (out_drive_torque !== due_torque) begin
          $display("%0t: drive_torque mismatch, expected %0d, got %0d", $time,
                   due_torque, out_drive_torque);
          fail_count++;
        end
      end
    end
  end

  initial begin
    logic signed [ANGLE_W-1:0] meas, targ;
    logic                      manual;

    steer_cfg.gain_prop = RST_GAIN_PROP;
    steer_cfg.gain_integ = RST_GAIN_INTEG;
    steer_cfg.gain_deriv = RST_GAIN_DERIV;
    steer_cfg.inv_period = RST_INV_PERIOD;
    steer_cfg.integ_limit = RST_INTEG_LIM;
    steer_cfg.torque_limit = RST_TORQUE_LIM;
    steer_cfg.small_err = RST_SMALL_ERR;
    integ_sum = 0;
    prev_angle = 0;
    prev_seen = 1'b0;

    // Defaults after reset; a typed torque is one that follows at a glance.
    dir_rows = '{
      '{16'sd0,      16'sd0,      1'b0, 1'b1, 16'sd0},
      '{16'sd16,     16'sd32,     1'b0, 1'b0, 16'sd0},
      '{16'sd1000,  -16'sd1000,   1'b1, 1'b0, 16'sd0},
      '{16'sd16,     16'sd16,     1'b0, 1'b1, 16'sd0},
      '{16'sd17,     16'sd16,     1'b0, 1'b0, 16'sd0},
      '{16'sh8000,   16'sd32767,  1'b0, 1'b1, 16'sd2000},
      '{16'sd32767,  16'sh8000,   1'b0, 1'b1, -16'sd2000},
      '{16'sd32767,  16'sd32767,  1'b0, 1'b0, 16'sd0},
      '{16'sd0,      16'sd159,    1'b0, 1'b0, 16'sd0},
      '{16'sd0,      16'sd160,    1'b0, 1'b0, 16'sd0},
      '{16'sd0,     -16'sd159,    1'b0, 1'b0, 16'sd0},
      '{16'sd0,     -16'sd160,    1'b0, 1'b0, 16'sd0},
      '{16'sh8000,   16'sd32767,  1'b1, 1'b0, 16'sd0},
      '{16'sh8000,   16'sh8000,   1'b1, 1'b0, 16'sd0},
      '{16'sh8000,   16'sh8000,   1'b0, 1'b0, 16'sd0},
      '{16'sd21845,  16'shAAAA,   1'b0, 1'b0, 16'sd0},
      '{16'shAAAA,   16'sd21845,  1'b0, 1'b0, 16'sd0}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      sender_pause();
      send_request(dir_rows[i].meas, dir_rows[i].targ, dir_rows[i].manual,
                   dir_rows[i].known, dir_rows[i].torque);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          // Every bit set: gains mask down to their full scale.
          raw = '{'1, '1, '1, '1, '1, '1, '1};
        end
        1: begin
          // Zero rate, zero limits, zero gains.
          raw = '{'0, '0, '0, '0, '0, '0, '0};
        end
        PHASES - 1: begin
          raw = '{CFG_W'(RST_GAIN_PROP), CFG_W'(RST_GAIN_INTEG), CFG_W'(RST_GAIN_DERIV),
                  CFG_W'(RST_INV_PERIOD), CFG_W'(RST_INTEG_LIM), CFG_W'(RST_TORQUE_LIM),
                  CFG_W'(RST_SMALL_ERR)};
        end
        default: begin
          raw = '{rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                  rand_limit(), rand_limit(), rand_limit()};
          // Odd derivative gain shows the truncation when it is halved.
          if (ph == 2) raw.gd = CFG_W'($urandom_range(511) * 2 + 1);
        end
      endcase
      load_registers(raw, ph == 3);
      calm = (ph == PHASES - 1);
      gap_pct = $urandom_range(2) * 25;
      stall_pct = $urandom_range(2) * 25;
      repeat (RAND_ITEMS / PHASES) begin
        next_random(meas, targ, manual);
        sender_pause();
        send_request(meas, targ, manual, 1'b0, '0);
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/stpid_pkg.sv
hw/rtl/stpid_seq.sv
hw/rtl/stpid_dp.sv
hw/rtl/steering_torque_pid_unit.sv
hw/rtl/stpid_chk.sv
tb/sv/tb_steering_torque_pid_unit.sv
